// File: design/ms_pkg.sv
// Shared types for the merge sorter: transaction payloads, controller states,
// and the command/status structs between controller and datapath.
// No dependencies.
package ms_pkg;

   // Input transaction: one element of the set
   typedef struct packed {
      logic signed [31:0] value;
      logic               is_last;
   } req_type;

   // Result transaction: one element of the sorted set
   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               is_last_res;
      logic               overflow;
   } rsp_type;

   // Controller states, one-hot
   typedef enum logic [4:0] {
      S_IDLE       = 5'b00001,
      S_SETUP      = 5'b00010,
      S_MERGE      = 5'b00100,
      S_EMIT_SETUP = 5'b01000,
      S_EMIT       = 5'b10000
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;        // store the accepted transaction
      logic sort_init;   // set up the run width and source store for the first merge pass
      logic pass_setup;  // point at the first run pair of a pass
      logic merge_step;  // move one element into the destination store
      logic emit_setup;  // point at the first sorted element
      logic emit_try;    // hand one element to the output register if free
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic single_elem; // store empty before this load
      logic seg_last;    // this merge step writes the last slot of the run pair
      logic pass_last;   // the current run pair ends the pass
      logic sort_done;   // the current pass is the final one
      logic emit_last;   // the element being emitted is the final one
      logic out_free;    // output register can take a new element
   } status_type;

endpackage

// File: design/ms_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module ms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   // Write one entry, register both reads
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

// File: design/ms_ctrl.sv
// Sequencer for the merge sorter: load, merge passes, emission.
// Depends on ms_pkg.
module ms_ctrl
   import ms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_is_last,
   input  status_type status,
   output logic       req_stall,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // Accept input only while idle
   assign req_stall = (state_ff != S_IDLE);

   // Next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_is_last) begin
                  cmd.sort_init = 1'b1;
                  state_in      = status.single_elem ? S_EMIT_SETUP : S_SETUP;
               end
            end
         end
         S_SETUP: begin
            cmd.pass_setup = 1'b1;
            state_in       = S_MERGE;
         end
         S_MERGE: begin
            cmd.merge_step = 1'b1;
            if (status.seg_last && status.pass_last) begin
               state_in = status.sort_done ? S_EMIT_SETUP : S_SETUP;
            end
         end
         S_EMIT_SETUP: begin
            cmd.emit_setup = 1'b1;
            state_in       = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit_try = 1'b1;
            if (status.out_free && status.emit_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/ms_dp.sv
// Datapath for the merge sorter: element count, ping-pong stores, merge
// pointers, comparator and output register. Depends on ms_pkg and ms_ram.
module ms_dp
   import ms_pkg::*;
#(
   parameter int MAX_ELEMS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  req_type    req_payload,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output rsp_type    rsp_payload
);

   localparam int CNT_W = $clog2(MAX_ELEMS + 1);
   localparam int IDX_W = $clog2(MAX_ELEMS);
   localparam int SUM_W = CNT_W + 3;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             drop_ff, drop_in;
   logic             sel_ff, sel_in;
   logic [CNT_W:0]   w_ff, w_in;
   logic [CNT_W-1:0] a_ff, a_in;
   logic [CNT_W-1:0] b_ff, b_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] e_ff, e_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             we0, we1;
   logic [IDX_W-1:0] waddr;
   logic [31:0]      wdata;
   logic [IDX_W-1:0] raddr_a, raddr_b;
   logic [31:0]      rd0_a, rd0_b, rd1_a, rd1_b;
   logic [31:0]      src_a, src_b;

   logic [SUM_W-1:0] n_wide, w_wide, hi_wide;
   logic [SUM_W-1:0] sum_mid0, sum_hi0, sum_mid1, sum_hi1;
   logic [CNT_W-1:0] mid0, hi0, mid1, hi1;
   logic             full, a_ok, b_ok, take_a;

   // Run boundaries, clamped to the element count
   assign n_wide   = SUM_W'(count_ff);
   assign w_wide   = SUM_W'(w_ff);
   assign hi_wide  = SUM_W'(hi_ff);
   assign sum_mid0 = w_wide;
   assign sum_hi0  = w_wide << 1;
   assign sum_mid1 = hi_wide + w_wide;
   assign sum_hi1  = hi_wide + (w_wide << 1);
   assign mid0 = (sum_mid0 > n_wide) ? count_ff : sum_mid0[CNT_W-1:0];
   assign hi0  = (sum_hi0  > n_wide) ? count_ff : sum_hi0[CNT_W-1:0];
   assign mid1 = (sum_mid1 > n_wide) ? count_ff : sum_mid1[CNT_W-1:0];
   assign hi1  = (sum_hi1  > n_wide) ? count_ff : sum_hi1[CNT_W-1:0];

   // Source store data, picked by the ping-pong select
   assign src_a = sel_ff ? rd1_a : rd0_a;
   assign src_b = sel_ff ? rd1_b : rd0_b;

   // Merge decision: left run wins ties
   assign full   = (count_ff == CNT_W'(MAX_ELEMS));
   assign a_ok   = (a_ff < mid_ff);
   assign b_ok   = (b_ff < hi_ff);
   assign take_a = a_ok && (!b_ok || ($signed(src_a) <= $signed(src_b)));

   // Status to the controller
   assign status.single_elem = (count_ff == '0);
   assign status.seg_last    = (({1'b0, k_ff} + 1'b1) == {1'b0, hi_ff});
   assign status.pass_last   = (hi_ff == count_ff);
   assign status.sort_done   = (sum_hi0 >= n_wide);
   assign status.emit_last   = (({1'b0, e_ff} + 1'b1) == {1'b0, count_ff});
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   // Next-state logic for counters, pointers, stores and output register
   always_comb begin
      count_in     = count_ff;
      drop_in      = drop_ff;
      sel_in       = sel_ff;
      w_in         = w_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      k_in         = k_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      e_in         = e_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      we0          = 1'b0;
      we1          = 1'b0;
      waddr        = k_ff[IDX_W-1:0];
      wdata        = take_a ? src_a : src_b;

      // Drop the output transaction once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Store an element, or flag it as dropped when full
      if (cmd.load) begin
         if (!full) begin
            we0      = 1'b1;
            waddr    = count_ff[IDX_W-1:0];
            wdata    = req_payload.value;
            count_in = count_ff + 1'b1;
         end else begin
            drop_in = 1'b1;
         end
      end

      if (cmd.sort_init) begin
         w_in   = (CNT_W + 1)'(1);
         sel_in = 1'b0;
      end

      // Point at the first run pair of the pass
      if (cmd.pass_setup) begin
         a_in   = '0;
         mid_in = mid0;
         b_in   = mid0;
         hi_in  = hi0;
         k_in   = '0;
      end

      // Move one element into the destination store
      if (cmd.merge_step) begin
         we0  = sel_ff;
         we1  = !sel_ff;
         k_in = k_ff + 1'b1;
         if (take_a) begin
            a_in = a_ff + 1'b1;
         end else begin
            b_in = b_ff + 1'b1;
         end
         if (status.seg_last) begin
            if (status.pass_last) begin
               w_in   = w_ff << 1;
               sel_in = !sel_ff;
            end else begin
               a_in   = hi_ff;
               mid_in = mid1;
               b_in   = mid1;
               hi_in  = hi1;
               k_in   = hi_ff;
            end
         end
      end

      if (cmd.emit_setup) begin
         e_in = '0;
      end

      // Hand one sorted element to the output register; clear the set on the last
      if (cmd.emit_try && status.out_free) begin
         rsp_valid_in       = 1'b1;
         rsp_in.sorted_value = src_a;
         rsp_in.is_last_res = status.emit_last;
         rsp_in.overflow    = drop_ff;
         e_in               = e_ff + 1'b1;
         if (status.emit_last) begin
            count_in = '0;
            drop_in  = 1'b0;
         end
      end
   end

   // Read addresses follow the next pointer values, so the registered read data
   // matches the current pointers
   assign raddr_a = (cmd.emit_setup || cmd.emit_try) ? e_in[IDX_W-1:0] : a_in[IDX_W-1:0];
   assign raddr_b = b_in[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
      w_ff   <= w_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      k_ff   <= k_in;
      mid_ff <= mid_in;
      hi_ff  <= hi_in;
      e_ff   <= e_in;
      rsp_ff <= rsp_in;
   end

   // Data store and scratch store swap roles every pass
   ms_ram #(
      .WIDTH (32),
      .DEPTH (MAX_ELEMS)
   ) u_ram0 (
      .clock   (clock),
      .we      (we0),
      .waddr   (waddr),
      .wdata   (wdata),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (rd0_a),
      .rdata_b (rd0_b)
   );

   ms_ram #(
      .WIDTH (32),
      .DEPTH (MAX_ELEMS)
   ) u_ram1 (
      .clock   (clock),
      .we      (we1),
      .waddr   (waddr),
      .wdata   (wdata),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (rd1_a),
      .rdata_b (rd1_b)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: design/merge_sorter_core.sv
// Merge sorter top level: controller and datapath.
// Depends on ms_pkg, ms_ctrl, ms_dp (and through it ms_ram).
//
// Collects up to MAX_ELEMS signed 32-bit values, one per input transaction,
// into a store. The transaction flagged is_last closes the set; the block then
// stalls its input, sorts the n held values ascending by bottom-up merge passes
// (equal values keep their arrival order), and emits them one per result
// transaction, the final one marked is_last_res. Values beyond MAX_ELEMS are
// dropped and overflow is set on every result of that set. Sorting takes
// ceil(log2 n) passes, each moving one element per cycle through the
// two-read-port store; emission holds while the output is stalled. Input is
// accepted again once the last result is in the output register.
module merge_sorter_core
   import ms_pkg::*;
#(
   parameter int MAX_ELEMS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   cmd_type    cmd;
   status_type status;

   ms_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_last (req_payload.is_last),
      .status      (status),
      .req_stall   (req_stall),
      .cmd         (cmd)
   );

   ms_dp #(
      .MAX_ELEMS (MAX_ELEMS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: design/merge_sorter_core_chk.sv
// Port-level checker for merge_sorter_core, attached by bind.
// Depends on ms_pkg and merge_sorter_core.
module merge_sorter_core_chk
   import ms_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // A stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result transaction changed");

   // A closing transaction stops input for the sort
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.is_last |=> req_stall)
      else $error("input accepted right after closing transaction");

   // No input while a set is still being emitted
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.is_last_res |-> req_stall)
      else $error("input accepted during emission");

   // Out of reset the block is idle with no result pending
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_stall && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind merge_sorter_core merge_sorter_core_chk u_chk (.*);

// File: bench/sort_checker.sv
`timescale 1ns / 1ps
// Result checker for merge_sorter_core: watches both channels, predicts each sorted set.
// Depends on ms_pkg for the request and response payload types.
module sort_checker
   import ms_pkg::*;
#(
   parameter int MAX_ELEMS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      pending
);

   // Values of the set being collected, in arrival order
   logic signed [31:0] held_vals [MAX_ELEMS];
   int                 held_count;
   logic               held_dropped;

   // Sorted results still owed by the block, oldest first
   rsp_type            sorted_q [$];

   initial begin
      fail_count   = 0;
      pending      = 0;
      held_count   = 0;
      held_dropped = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH at %0t: %s: got %h, expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   // Sort the held set ascending and queue one expected result per value
   task automatic close_set();
      logic signed [31:0] key;
      rsp_type            item;
      int                 i;
      int                 j;
      for (i = 1; i < held_count; i++) begin
         key = held_vals[i];
         j = i - 1;
         while (j >= 0 && held_vals[j] > key) begin
            held_vals[j + 1] = held_vals[j];
            j--;
         end
         held_vals[j + 1] = key;
      end
      for (i = 0; i < held_count; i++) begin
         item.sorted_value = held_vals[i];
         item.is_last_res  = (i == held_count - 1);
         item.overflow     = held_dropped;
         sorted_q.insert(sorted_q.size(), item);
      end
      held_count   = 0;
      held_dropped = 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         held_count   = 0;
         held_dropped = 1'b0;
         sorted_q.delete();
      end else begin
         // Store an accepted request transaction, or drop it when full
         if (req_valid && !req_stall) begin
            if (held_count < MAX_ELEMS) begin
               held_vals[held_count] = req_payload.value;
               held_count++;
            end else begin
               held_dropped = 1'b1;
            end
            if (req_payload.is_last)
               close_set();
         end
         // Compare an accepted response transaction with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (sorted_q.size() == 0) begin
               report_mismatch("result with nothing outstanding", rsp_payload.sorted_value,
                               32'h0);
            end else begin
               want = sorted_q.pop_front();
               if (rsp_payload.sorted_value !== want.sorted_value)
                  report_mismatch("sorted_value", rsp_payload.sorted_value,
                                  want.sorted_value);
               if (rsp_payload.is_last_res !== want.is_last_res)
                  report_mismatch("is_last_res", 32'(rsp_payload.is_last_res),
                                  32'(want.is_last_res));
               if (rsp_payload.overflow !== want.overflow)
                  report_mismatch("overflow", 32'(rsp_payload.overflow),
                                  32'(want.overflow));
            end
         end
      end
      pending = sorted_q.size();
   end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Top of the merge sorter bench: clock, reset, stimulus sets and final verdict.
// Depends on ms_pkg, merge_sorter_core and sort_checker.
module testbench
   import ms_pkg::*;
();

   localparam int MAX_ELEMS = 64;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   req_type req_payload = '0;
   logic    rsp_stall   = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_payload;

   logic               quiet      = 1'b0;
   int                 item_count = 0;
   logic signed [31:0] prev_value = '0;
   int                 fail_count;
   int                 pending;

   merge_sorter_core #(.MAX_ELEMS(MAX_ELEMS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   sort_checker #(.MAX_ELEMS(MAX_ELEMS)) sort_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always #2 clock = ~clock;

   // Stall the response side at random, except during the quiet stretch
   always @(negedge clock) begin
      rsp_stall = !quiet && ($urandom_range(0, 99) < 14);
   end

   // Mix of full-range values, small values, extremes and repeats
   function automatic logic signed [31:0] rand_value(input logic signed [31:0] prev);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom;
         5, 6:          return $signed($urandom_range(0, 8)) - 4;
         7:             return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         8:             return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                                    : 32'h8000_0000 + $urandom_range(0, 3);
         default:       return prev;
      endcase
   endfunction

   // Drive one request transaction and hold it until accepted
   task automatic send_item(input logic signed [31:0] value, input logic last);
      @(negedge clock);
      quiet = (item_count >= 120 && item_count < 220);
      while (!quiet && $urandom_range(0, 99) < 14) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_payload.value   = value;
      req_payload.is_last = last;
      req_valid           = 1'b1;
      prev_value          = value;
      item_count++;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Send a set of random values closed by is_last
   task automatic send_set(input int size);
      int i;
      for (i = 0; i < size; i++)
         send_item(rand_value(prev_value), i == size - 1);
   endtask

   // Drop valid and hold off until every outstanding result has arrived
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0)
         @(negedge clock);
   endtask

   initial begin
      int sent;
      int size;
      int k;
      repeat (9) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // Single element set at the most negative value
      send_item(32'sh8000_0000, 1'b1);
      // Two element set, reversed
      send_item(32'sd5, 1'b0);
      send_item(-32'sd5, 1'b1);
      // Extremes with repeated values
      send_item(32'sh7FFF_FFFF, 1'b0);
      send_item(32'sh8000_0000, 1'b0);
      send_item(32'sd0, 1'b0);
      send_item(-32'sd1, 1'b0);
      send_item(32'sd1, 1'b0);
      send_item(32'sh7FFF_FFFF, 1'b0);
      send_item(32'sh8000_0000, 1'b0);
      send_item(-32'sd1, 1'b1);
      // Already ascending
      send_item(-32'sd3, 1'b0);
      send_item(-32'sd2, 1'b0);
      send_item(-32'sd1, 1'b0);
      send_item(32'sd0, 1'b0);
      send_item(32'sd2, 1'b1);
      // Strictly descending
      send_item(32'sd40, 1'b0);
      send_item(32'sd30, 1'b0);
      send_item(32'sd20, 1'b0);
      send_item(-32'sd10, 1'b0);
      send_item(-32'sd20, 1'b1);
      wait_drained();

      // Random sets: full store with is_last dropped, exactly full, overflow, then mixed
      sent = 0;
      k    = 0;
      while (sent < 300) begin
         case (k)
            0:       size = MAX_ELEMS + 1;
            1:       size = MAX_ELEMS;
            2:       size = MAX_ELEMS + 6;
            default: size = ($urandom_range(0, 9) == 0)
                            ? $urandom_range(MAX_ELEMS - 4, MAX_ELEMS + 4)
                            : $urandom_range(1, 12);
         endcase
         send_set(size);
         sent += size;
         k++;
         if ($urandom_range(0, 9) == 0)
            wait_drained();
      end

      @(negedge clock) req_valid = 1'b0;
      quiet = 1'b0;
      wait_drained();
      repeat (40) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Give up on a hung run
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
